// ===== hw/rtl/swmf_pkg.sv =====
// Shared types and constants of the sliding window median filter.
// Holds the request and result payloads and the neighbor links of the sorted cell chain.
// Depends on nothing; the core, cell and median files refer to it by scoped names.
`default_nettype none

package swmf_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    clear;
  } request_t;

  typedef struct packed {
    sample_t               median;
    logic [COUNT_BITS-1:0] fill_count;
  } result_t;

  // Stored entry of a cell as seen by its left neighbor.
  typedef struct packed {
    logic    valid;
    logic    gt;
    sample_t val;
  } right_link_t;

  // Entry of a cell after the evicted sample is removed, as seen by its right neighbor.
  typedef struct packed {
    logic    valid;
    logic    below;
    sample_t val;
  } left_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swmf_stream_if.sv =====
// Valid/ready stream channel used for the request and result sides of the filter.
// The payload type is chosen by the instantiating level, normally a type of swmf_pkg.
`default_nettype none

interface swmf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sliding_window_median_filter_core.sv =====
// Running median over the last WINDOW samples, built as a sorted chain of cells.
// Depends on swmf_pkg, swmf_stream_if, swmf_cell and swmf_median.
//
// Usage: each request on the samples channel carries one signed sample and a clear
// flag. A request without clear inserts the sample into the window, replacing the
// oldest one once WINDOW samples are held; a request with clear empties the window.
// Every request yields exactly one result on the results channel: the median of the
// held samples (the floored mean of the middle pair for an even count, zero when
// empty) and the fill count.
// The chain updates at the edge that accepts a request; the median is taken from the
// chain and registered in the output register when that request moves to the output,
// which waits while the receiver stalls. The block accepts one request per cycle
// while results are taken, limited by the single update of the cell chain per clock.
// When the receiver stalls, one result waits in the output register and one more
// request may be accepted and held in the chain; further requests then wait.
// Synchronous reset empties the window and drops any request in flight.
`default_nettype none

module sliding_window_median_filter_core #(
  parameter int unsigned WINDOW = 16
) (
  input  logic         clk,
  input  logic         rst,
  swmf_stream_if.sink   samples,
  swmf_stream_if.source results
);

  localparam int unsigned AGE_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_BITS = $clog2(WINDOW + 1);

  logic                  pend;
  logic                  out_valid;
  logic                  move;
  logic                  accept;
  logic                  flush;
  logic                  load;
  logic                  full;
  logic [CNT_BITS-1:0]   cnt;
  logic [CNT_BITS-1:0]   cnt_next;
  swmf_pkg::sample_t     ev;
  swmf_pkg::sample_t     vals [WINDOW];
  logic [WINDOW-1:0]     evict_vec;
  logic [WINDOW-1:0]     valid_vec;
  swmf_pkg::right_link_t link_r [WINDOW+1];
  logic [AGE_BITS-1:0]   age_r [WINDOW+1];
  swmf_pkg::left_link_t  link_l [WINDOW+1];
  logic [AGE_BITS-1:0]   age_l [WINDOW+1];

  assign move          = pend && (!out_valid || results.ready);
  assign samples.ready = !pend || move;
  assign accept        = samples.valid && samples.ready;
  assign flush         = accept && samples.payload.clear;
  assign load          = accept && !samples.payload.clear;
  assign full          = (cnt == CNT_BITS'(WINDOW));
  assign results.valid = out_valid;

  assign link_r[WINDOW] = '{valid: 1'b0, gt: 1'b0, val: '0};
  assign age_r[WINDOW]  = '0;
  assign link_l[0]      = '{valid: 1'b0, below: 1'b1, val: '0};
  assign age_l[0]       = '0;

  for (genvar j = 0; j < WINDOW; j++) begin : g_cell
    swmf_cell #(
      .WINDOW   (WINDOW),
      .AGE_BITS (AGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .flush     (flush),
      .load      (load),
      .full      (full),
      .x         (samples.payload.sample),
      .ev        (ev),
      .right     (link_r[j+1]),
      .right_age (age_r[j+1]),
      .left      (link_l[j]),
      .left_age  (age_l[j]),
      .own       (link_r[j]),
      .own_age   (age_r[j]),
      .rem       (link_l[j+1]),
      .rem_age   (age_l[j+1]),
      .evict     (evict_vec[j]),
      .value     (vals[j])
    );
    assign valid_vec[j] = link_r[j].valid;
  end

  always_comb begin
    ev = '0;
    for (int unsigned j = 0; j < WINDOW; j++) begin
      ev = ev | (vals[j] & {swmf_pkg::SAMPLE_BITS{evict_vec[j]}});
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (flush) begin
      cnt_next = '0;
    end else if (load && !full) begin
      cnt_next = cnt + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      pend <= accept || (pend && !move);
      if (move) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  swmf_median #(
    .WINDOW     (WINDOW),
    .INDEX_BITS (AGE_BITS),
    .CNT_BITS   (CNT_BITS)
  ) u_median (
    .clk     (clk),
    .capture (move),
    .vals    (vals),
    .count   (cnt),
    .result  (results.payload)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(WINDOW))
    else $error("fill count exceeds the window");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("number of occupied cells differs from fill count");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + WINDOW'(1))) == '0)
    else $error("occupied cells are not packed from the low end");

  a_single_oldest: assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(evict_vec))
    else $error("full window does not hold exactly one oldest sample");

endmodule

`default_nettype wire

// ===== hw/rtl/swmf_cell.sv =====
// One cell of the sorted chain: holds one sample and its age in the window.
// Each update removes the evicted sample and inserts the new one from neighbor data.
// Depends on swmf_pkg.
`default_nettype none

module swmf_cell #(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned AGE_BITS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     flush,
  input  logic                     load,
  input  logic                     full,
  input  swmf_pkg::sample_t        x,
  input  swmf_pkg::sample_t        ev,
  input  swmf_pkg::right_link_t    right,
  input  logic [AGE_BITS-1:0]      right_age,
  input  swmf_pkg::left_link_t     left,
  input  logic [AGE_BITS-1:0]      left_age,
  output swmf_pkg::right_link_t    own,
  output logic [AGE_BITS-1:0]      own_age,
  output swmf_pkg::left_link_t     rem,
  output logic [AGE_BITS-1:0]      rem_age,
  output logic                     evict,
  output swmf_pkg::sample_t        value
);

  logic                valid;
  swmf_pkg::sample_t   val;
  logic [AGE_BITS-1:0] age;
  logic                valid_next;
  swmf_pkg::sample_t   val_next;
  logic [AGE_BITS-1:0] age_next;
  logic                gt;
  logic                shift;
  logic                rem_gt;

  // With a full window the oldest sample sits left of every equal value, so any
  // entry not below it moves one place left once it is removed.
  assign gt    = valid && (val > x);
  assign shift = full && (ev <= val);
  assign evict = valid && (age == AGE_BITS'(WINDOW - 1));
  assign value = val;

  assign own.valid = valid;
  assign own.gt    = gt;
  assign own.val   = val;
  assign own_age   = age;

  assign rem.valid = shift ? right.valid : valid;
  assign rem.val   = shift ? right.val : val;
  assign rem_age   = shift ? right_age : age;
  assign rem_gt    = shift ? right.gt : gt;
  assign rem.below = rem.valid && !rem_gt;

  always_comb begin
    valid_next = valid;
    val_next   = val;
    age_next   = age;
    if (flush) begin
      valid_next = 1'b0;
    end else if (load) begin
      priority if (rem.below) begin
        valid_next = rem.valid;
        val_next   = rem.val;
        age_next   = rem_age + AGE_BITS'(1);
      end else if (left.below) begin
        valid_next = 1'b1;
        val_next   = x;
        age_next   = '0;
      end else begin
        valid_next = left.valid;
        val_next   = left.val;
        age_next   = left_age + AGE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    val <= val_next;
    age <= age_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swmf_median.sv =====
// Median stage: middle entry or mean of the middle pair of the chain, zero if empty.
// Registers the result payload when a finished request moves to the output.
// Depends on swmf_pkg.
`default_nettype none

module swmf_median #(
  parameter int unsigned WINDOW     = 16,
  parameter int unsigned INDEX_BITS = 4,
  parameter int unsigned CNT_BITS   = 5
) (
  input  logic                 clk,
  input  logic                 capture,
  input  swmf_pkg::sample_t    vals [WINDOW],
  input  logic [CNT_BITS-1:0]  count,
  output swmf_pkg::result_t    result
);

  logic [CNT_BITS-1:0]                half;
  logic [INDEX_BITS-1:0]              hi_idx;
  logic [INDEX_BITS-1:0]              lo_idx;
  logic signed [swmf_pkg::SAMPLE_BITS:0] pair_sum;
  swmf_pkg::sample_t                  med;

  assign half     = count >> 1;
  assign hi_idx   = INDEX_BITS'(half);
  assign lo_idx   = INDEX_BITS'(half - CNT_BITS'(1));
  assign pair_sum = {vals[hi_idx][swmf_pkg::SAMPLE_BITS-1], vals[hi_idx]}
                  + {vals[lo_idx][swmf_pkg::SAMPLE_BITS-1], vals[lo_idx]};

  always_comb begin
    priority if (count == '0) begin
      med = '0;
    end else if (count[0]) begin
      med = vals[hi_idx];
    end else begin
      med = pair_sum[swmf_pkg::SAMPLE_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      result.median     <= med;
      result.fill_count <= swmf_pkg::COUNT_BITS'(count);
    end
  end

endmodule

`default_nettype wire
